// File: rtl/core/columnar_transposition_cipher_core_defines.svh
// Assertion macros shared by the cipher core.
// Both expect clk_i and rst_ni in scope.
`ifndef COLUMNAR_TRANSPOSITION_CIPHER_CORE_DEFINES_SVH
`define COLUMNAR_TRANSPOSITION_CIPHER_CORE_DEFINES_SVH

// same-cycle implication
`define CTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ctc: same-cycle check failed");

// next-cycle implication
`define CTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ctc: next-cycle check failed");

`endif

// File: rtl/core/ctc_pkg.sv
package ctc_pkg;

  localparam int unsigned BufDepth   = 64;
  localparam int unsigned MaxKey     = 8;
  localparam int unsigned AddrW      = $clog2(BufDepth);
  localparam int unsigned CntW       = $clog2(BufDepth + 1);
  localparam int unsigned KlW        = 4;
  localparam int unsigned RankW      = 4;
  localparam int unsigned RanksW     = 32;
  localparam int unsigned KeyIdxW    = $clog2(MaxKey);
  localparam int unsigned OrdCntW    = KeyIdxW + 1;
  localparam int unsigned RecipShift = 10;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned PosW       = 2 * CntW + 1;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QDepth     = 1 << QPtrW;

  typedef logic [7:0] char_t;

  localparam char_t ChLowA   = 8'h61;
  localparam char_t ChLowZ   = 8'h7a;
  localparam char_t ChPadLo  = 8'h78;  // 'x'
  localparam char_t ChPadUp  = 8'h58;  // 'X'
  localparam char_t ChShift  = 8'd32;

  typedef enum logic [1:0] {
    CfgKeyLength   = 2'd0,
    CfgKeyRanks    = 2'd1,
    CfgDecryptMode = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BIdle,
    BRows,
    BRank,
    BFill,
    BEmit
  } back_state_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    char_t            data;
  } buf_wr_t;

  typedef struct packed {
    logic [CntW-1:0]   n;
    logic              ov;
    logic [KlW-1:0]    kl;
    logic [RanksW-1:0] ranks;
    logic              dec;
  } job_t;

  // 0 acts as 1, anything above MaxKey as MaxKey
  function automatic logic [KlW-1:0] eff_len(input logic [KlW-1:0] k);
    logic [KlW-1:0] r;
    r = k;
    if (k == '0) r = KlW'(1);
    else if (k > KlW'(MaxKey)) r = KlW'(MaxKey);
    return r;
  endfunction

  // largest multiple of k that fits in the buffer
  function automatic logic [CntW-1:0] line_cap(input logic [KlW-1:0] k);
    logic [CntW-1:0] r;
    unique case (k)
      4'd1:    r = CntW'((BufDepth / 1) * 1);
      4'd2:    r = CntW'((BufDepth / 2) * 2);
      4'd3:    r = CntW'((BufDepth / 3) * 3);
      4'd4:    r = CntW'((BufDepth / 4) * 4);
      4'd5:    r = CntW'((BufDepth / 5) * 5);
      4'd6:    r = CntW'((BufDepth / 6) * 6);
      4'd7:    r = CntW'((BufDepth / 7) * 7);
      4'd8:    r = CntW'((BufDepth / 8) * 8);
      default: r = CntW'(BufDepth);
    endcase
    return r;
  endfunction

  // ceil(2^RecipShift / k); exact quotient for dividends below 128
  function automatic logic [RecipW-1:0] recip(input logic [KlW-1:0] k);
    logic [RecipW-1:0] r;
    unique case (k)
      4'd2:    r = RecipW'(((1 << RecipShift) + 1) / 2);
      4'd3:    r = RecipW'(((1 << RecipShift) + 2) / 3);
      4'd4:    r = RecipW'(((1 << RecipShift) + 3) / 4);
      4'd5:    r = RecipW'(((1 << RecipShift) + 4) / 5);
      4'd6:    r = RecipW'(((1 << RecipShift) + 5) / 6);
      4'd7:    r = RecipW'(((1 << RecipShift) + 6) / 7);
      4'd8:    r = RecipW'(((1 << RecipShift) + 7) / 8);
      default: r = RecipW'(1 << RecipShift);
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/ctc_buf.sv
module ctc_buf (
  input  logic                        clk_i,
  input  ctc_pkg::buf_wr_t            wr_i,
  input  logic                        rd_en_i,
  input  logic [ctc_pkg::AddrW-1:0]   rd_addr_i,
  output ctc_pkg::char_t              rd_data_o
);

  ctc_pkg::char_t mem_q [ctc_pkg::BufDepth];
  ctc_pkg::char_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/ctc_queue.sv
module ctc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ctc_pkg::job_t job_i,
  input  logic          pop_i,
  output ctc_pkg::job_t job_o,
  output logic          empty_o,
  output logic          full_o
);

  ctc_pkg::job_t                ent_q [ctc_pkg::QDepth];
  logic [ctc_pkg::QPtrW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [ctc_pkg::QPtrW:0]      cnt_q, cnt_d;

  always_comb begin
    wp_d  = push_i ? wp_q + ctc_pkg::QPtrW'(1) : wp_q;
    rp_d  = pop_i ? rp_q + ctc_pkg::QPtrW'(1) : rp_q;
    cnt_d = cnt_q + (ctc_pkg::QPtrW + 1)'(push_i) - (ctc_pkg::QPtrW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= job_i;
    end
  end

  assign job_o   = ent_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (ctc_pkg::QPtrW + 1)'(ctc_pkg::QDepth));

endmodule

// File: rtl/core/ctc_front.sv
module ctc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [ctc_pkg::RanksW-1:0]   cfg_data_i,
  input  ctc_pkg::char_t               char_in_i,
  input  logic                         has_char_i,
  input  logic                         line_end_i,
  output ctc_pkg::buf_wr_t             buf_wr_o,
  output logic                         push_o,
  output ctc_pkg::job_t                job_o
);

  logic [ctc_pkg::KlW-1:0]    key_len_q;
  logic [ctc_pkg::RanksW-1:0] ranks_q;
  logic                       dec_q;
  logic [ctc_pkg::CntW-1:0]   stored_q, stored_d;
  logic                       dropped_q, dropped_d;

  logic [ctc_pkg::KlW-1:0]  kl;
  logic [ctc_pkg::CntW-1:0] cap, stored_new, n;
  logic                     keep, do_wr, dropped_new, over;

  always_comb begin
    kl          = ctc_pkg::eff_len(key_len_q);
    cap         = ctc_pkg::line_cap(kl);
    keep        = accept_i && has_char_i &&
                  (dec_q || (char_in_i >= ctc_pkg::ChLowA && char_in_i <= ctc_pkg::ChLowZ));
    do_wr       = keep && (stored_q < cap);
    stored_new  = stored_q + ctc_pkg::CntW'(do_wr);
    dropped_new = dropped_q || (keep && !do_wr);
    // key length may have shrunk the capacity mid-line
    over        = stored_new > cap;
    n           = over ? cap : stored_new;

    buf_wr_o.en   = do_wr;
    buf_wr_o.addr = stored_q[ctc_pkg::AddrW-1:0];
    buf_wr_o.data = char_in_i;

    push_o      = accept_i && line_end_i && (n != '0);
    job_o.n     = n;
    job_o.ov    = dropped_new || over;
    job_o.kl    = kl;
    job_o.ranks = ranks_q;
    job_o.dec   = dec_q;

    if (accept_i && line_end_i) begin
      stored_d  = '0;
      dropped_d = 1'b0;
    end else begin
      stored_d  = stored_new;
      dropped_d = dropped_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= ctc_pkg::KlW'(5);
      ranks_q   <= ctc_pkg::RanksW'(32'h0005_4321);
      dec_q     <= 1'b0;
      stored_q  <= '0;
      dropped_q <= 1'b0;
    end else begin
      stored_q  <= stored_d;
      dropped_q <= dropped_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ctc_pkg::CfgKeyLength:   key_len_q <= cfg_data_i[ctc_pkg::KlW-1:0];
          ctc_pkg::CfgKeyRanks:    ranks_q   <= cfg_data_i;
          ctc_pkg::CfgDecryptMode: dec_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/ctc_back.sv
module ctc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  ctc_pkg::job_t               job_i,
  output logic                        pop_o,
  output logic                        active_o,
  output logic                        rd_en_o,
  output logic [ctc_pkg::AddrW-1:0]   rd_addr_o,
  input  ctc_pkg::char_t              rd_data_i,
  output ctc_pkg::char_t              char_out_o,
  output logic                        last_o,
  output logic                        overflow_o,
  output logic                        valid_o
);

  localparam int unsigned CntW    = ctc_pkg::CntW;
  localparam int unsigned KeyIdxW = ctc_pkg::KeyIdxW;
  localparam int unsigned MaxKey  = ctc_pkg::MaxKey;

  ctc_pkg::back_state_e state_q, state_d;
  ctc_pkg::job_t        job_q;

  logic [CntW-1:0]             rows_q, rows_d;
  logic [ctc_pkg::RankW-1:0]   rank_q;
  logic [ctc_pkg::OrdCntW-1:0] ocnt_q;
  logic [MaxKey-1:0]           used_q;
  logic [KeyIdxW-1:0]          order_q [MaxKey];
  logic [KeyIdxW-1:0]          slot_q  [MaxKey];
  logic [CntW-1:0]             inner_q, outer_q;

  logic s1_valid_q, s1_pad_q, s1_last_q, s1_dec_q, s1_ov_q;
  logic valid_q, last_q, ov_q;
  ctc_pkg::char_t char_q;

  // control from the sequencer
  logic do_load, do_rows, do_find, do_emit, fill_mode;

  // column picker
  logic [MaxKey-1:0]  cand;
  logic               found;
  logic [KeyIdxW-1:0] pick;

  // row count and address generation
  logic [CntW-1:0]                     div_x;
  logic [CntW+ctc_pkg::RecipW-1:0]     div_p;
  logic [CntW-1:0]                     inner_lim, outer_lim, op_a, op_b, op_c;
  logic                                inner_end, outer_end;
  logic [2*CntW-1:0]                   mul;
  logic [ctc_pkg::PosW-1:0]            pos;
  logic                                pad;

  always_comb begin
    for (int j = 0; j < MaxKey; j++) begin
      cand[j] = (ctc_pkg::KlW'(j) < job_q.kl) && !used_q[j] &&
                (fill_mode || job_q.ranks[ctc_pkg::RankW*j +: ctc_pkg::RankW] == rank_q);
    end
    found = |cand;
    pick  = '0;
    for (int j = int'(MaxKey) - 1; j >= 0; j--) begin
      if (cand[j]) pick = KeyIdxW'(j);
    end
  end

  always_comb begin
    div_x  = job_q.n + CntW'(job_q.kl) - CntW'(1);
    div_p  = div_x * ctc_pkg::recip(job_q.kl);
    rows_d = div_p[ctc_pkg::RecipShift +: CntW];
  end

  // encrypt walks columns in rank order then rows; decrypt walks rows then columns
  always_comb begin
    inner_lim = job_q.dec ? CntW'(job_q.kl) : rows_q;
    outer_lim = job_q.dec ? rows_q : CntW'(job_q.kl);
    inner_end = (inner_q == inner_lim - CntW'(1));
    outer_end = (outer_q == outer_lim - CntW'(1));
    op_a      = job_q.dec ? CntW'(slot_q[inner_q[KeyIdxW-1:0]]) : inner_q;
    op_b      = job_q.dec ? rows_q : CntW'(job_q.kl);
    op_c      = job_q.dec ? outer_q : CntW'(order_q[outer_q[KeyIdxW-1:0]]);
    mul       = op_a * op_b;
    pos       = {1'b0, mul} + ctc_pkg::PosW'(op_c);
    pad       = pos >= ctc_pkg::PosW'(job_q.n);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctc_pkg::BIdle: if (!q_empty_i) state_d = ctc_pkg::BRows;
      ctc_pkg::BRows: state_d = ctc_pkg::BRank;
      ctc_pkg::BRank: if (rank_q == job_q.kl) state_d = ctc_pkg::BFill;
      ctc_pkg::BFill: if (!found) state_d = ctc_pkg::BEmit;
      ctc_pkg::BEmit: if (inner_end && outer_end) state_d = ctc_pkg::BIdle;
      default:        state_d = ctc_pkg::BIdle;
    endcase
  end

  always_comb begin
    do_load   = 1'b0;
    do_rows   = 1'b0;
    do_find   = 1'b0;
    do_emit   = 1'b0;
    fill_mode = 1'b0;
    unique case (state_q)
      ctc_pkg::BIdle: do_load = !q_empty_i;
      ctc_pkg::BRows: do_rows = 1'b1;
      ctc_pkg::BRank: do_find = found;
      ctc_pkg::BFill: begin
        fill_mode = 1'b1;
        do_find   = found;
      end
      ctc_pkg::BEmit: do_emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ctc_pkg::BIdle;
      s1_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= do_emit;
      valid_q    <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      job_q <= job_i;
    end
    if (do_rows) begin
      rows_q  <= rows_d;
      rank_q  <= ctc_pkg::RankW'(1);
      ocnt_q  <= '0;
      used_q  <= '0;
      inner_q <= '0;
      outer_q <= '0;
    end
    if (state_q == ctc_pkg::BRank) begin
      rank_q <= rank_q + ctc_pkg::RankW'(1);
    end
    if (do_find) begin
      order_q[ocnt_q[KeyIdxW-1:0]] <= pick;
      slot_q[pick]                 <= ocnt_q[KeyIdxW-1:0];
      used_q[pick]                 <= 1'b1;
      ocnt_q                       <= ocnt_q + ctc_pkg::OrdCntW'(1);
    end
    if (do_emit) begin
      if (inner_end) begin
        inner_q <= '0;
        outer_q <= outer_q + CntW'(1);
      end else begin
        inner_q <= inner_q + CntW'(1);
      end
    end
    s1_pad_q  <= pad;
    s1_last_q <= inner_end && outer_end;
    s1_dec_q  <= job_q.dec;
    s1_ov_q   <= job_q.ov;
    last_q    <= s1_last_q;
    ov_q      <= s1_ov_q;
    if (s1_pad_q) begin
      char_q <= s1_dec_q ? ctc_pkg::ChPadLo : ctc_pkg::ChPadUp;
    end else begin
      char_q <= s1_dec_q ? rd_data_i + ctc_pkg::ChShift : rd_data_i - ctc_pkg::ChShift;
    end
  end

  assign pop_o      = do_load;
  assign active_o   = (state_q != ctc_pkg::BIdle);
  assign rd_en_o    = do_emit;
  assign rd_addr_o  = pos[ctc_pkg::AddrW-1:0];
  assign char_out_o = char_q;
  assign last_o     = last_q;
  assign overflow_o = ov_q;
  assign valid_o    = valid_q;

endmodule

// File: rtl/core/columnar_transposition_cipher_core.sv
// Keyed columnar transposition of text lines. While busy is low one character
// request is taken per cycle (start high); the line buffer holds 64 characters.
// A request with line_end closes the line: if it holds any characters, busy
// rises the next cycle and stays high while the back end sets up and walks the
// buffer. Setup is a queue pop, a row count, a step per rank, a step for each
// column that no rank picks and a closing scan; then one buffer read per cycle
// yields one result, rows*key_length results in all, each registered in the
// buffer's read register and then the output register. The buffer's single read
// port sets the output rate of one character per cycle. Results are strobed on
// result_valid_o for exactly one cycle and cannot be held off by the receiver.
`include "columnar_transposition_cipher_core_defines.svh"

module columnar_transposition_cipher_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ctc_pkg::RanksW-1:0] cfg_data_i,
  input  logic [7:0]                 char_in_i,
  input  logic                       has_char_i,
  input  logic                       line_end_i,
  output logic [7:0]                 char_out_o,
  output logic                       last_o,
  output logic                       overflow_o,
  output logic                       result_valid_o
);

  ctc_pkg::buf_wr_t            buf_wr;
  ctc_pkg::job_t               job_in, job_out;
  ctc_pkg::char_t              rd_data;
  logic [ctc_pkg::AddrW-1:0]   rd_addr;
  logic                        accept, push, pop, q_empty, q_full, back_active, rd_en;

  assign accept = start && !busy;
  assign busy   = !q_empty || back_active;

  ctc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .char_in_i  (char_in_i),
    .has_char_i (has_char_i),
    .line_end_i (line_end_i),
    .buf_wr_o   (buf_wr),
    .push_o     (push),
    .job_o      (job_in)
  );

  ctc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  ctc_buf u_buf (
    .clk_i     (clk_i),
    .wr_i      (buf_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ctc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .job_i      (job_out),
    .pop_o      (pop),
    .active_o   (back_active),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .char_out_o (char_out_o),
    .last_o     (last_o),
    .overflow_o (overflow_o),
    .valid_o    (result_valid_o)
  );

  `CTC_ASSERT_NEXT(a_push_busy, push, busy)
  `CTC_ASSERT_IMP(a_wr_back_idle, buf_wr.en, !back_active)
  `CTC_ASSERT_IMP(a_push_room, push, !q_full)
  `CTC_ASSERT_NEXT(a_last_gap, result_valid_o && last_o, !result_valid_o)

endmodule
